// File: rtl/core/msd_pkg.sv
package msd_pkg;

  localparam int unsigned DUE_W   = 24;
  localparam int unsigned PROC_W  = 16;
  localparam int unsigned CLK_W   = 22;
  // Due date minus processing time, kept signed with one extra bit.
  localparam int unsigned DP_W    = DUE_W + 1;
  // Room for the subtraction of the dispatch clock from that difference.
  localparam int unsigned DIFF_W  = DP_W + 1;
  localparam int unsigned SLACK_W = DUE_W;

  typedef struct packed {
    logic [DUE_W-1:0]  due_date;
    logic [PROC_W-1:0] proc_time;
    logic              last_job;
  } in_t;

  typedef struct packed {
    logic [5:0]       job_index;
    logic [6:0]       position;
    logic [CLK_W-1:0] start_time;
    logic             overflow;
    logic             last_of_run;
  } out_t;

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  typedef struct packed {
    logic load;
    logic scan_init;
    logic scan_issue;
    logic commit;
    logic set_clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic pipe_busy;
    logic out_free;
    logic last_round;
  } dp_sts_t;

endpackage

// File: rtl/core/msd_ram.sv
module msd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/msd_ctrl.sv
module msd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_last_i,
  input  msd_pkg::dp_sts_t   sts_i,
  output logic               in_ready_o,
  output msd_pkg::ctrl_cmd_t cmd_o
);

  msd_pkg::state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      msd_pkg::ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            cmd_o.scan_init = 1'b1;
            state_d         = msd_pkg::ST_SCAN;
          end
        end
      end
      msd_pkg::ST_SCAN: begin
        // Reads go out one per cycle; the round ends once the compare stages drain.
        if (!sts_i.scan_end) begin
          cmd_o.scan_issue = 1'b1;
        end else if (!sts_i.pipe_busy) begin
          state_d = msd_pkg::ST_EMIT;
        end
      end
      msd_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          if (sts_i.last_round) begin
            cmd_o.set_clear = 1'b1;
            state_d         = msd_pkg::ST_LOAD;
          end else begin
            cmd_o.scan_init = 1'b1;
            state_d         = msd_pkg::ST_SCAN;
          end
        end
      end
      default: begin
        state_d = msd_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= msd_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/core/msd_dpath.sv
module msd_dpath #(
  parameter int unsigned MAX_JOBS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  msd_pkg::ctrl_cmd_t cmd_i,
  output msd_pkg::dp_sts_t   sts_o,
  input  msd_pkg::in_t       in_data_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output msd_pkg::out_t      out_data_o
);

  localparam int unsigned IW     = $clog2(MAX_JOBS);
  localparam int unsigned CW     = $clog2(MAX_JOBS + 1);
  localparam int unsigned WORD_W = msd_pkg::DP_W + msd_pkg::PROC_W;

  logic [CW-1:0]                count_q;
  logic                         overflow_q;
  logic [msd_pkg::CLK_W-1:0]    clock_q;
  logic [CW-1:0]                round_q;
  logic [CW-1:0]                scan_q;
  logic [MAX_JOBS-1:0]          done_q;

  logic                         s1_valid_q;
  logic [IW-1:0]                s1_idx_q;
  logic                         s2_valid_q;
  logic [IW-1:0]                s2_idx_q;
  logic [msd_pkg::SLACK_W-1:0]  s2_slack_q;
  logic [msd_pkg::PROC_W-1:0]   s2_proc_q;

  logic                         found_q;
  logic [msd_pkg::SLACK_W-1:0]  best_slack_q;
  logic [IW-1:0]                best_idx_q;
  logic [msd_pkg::PROC_W-1:0]   best_proc_q;

  logic                         out_valid_q;
  msd_pkg::out_t                out_q;

  logic                         full;
  logic                         last_round;
  logic [msd_pkg::DP_W-1:0]     wr_dp;
  logic [WORD_W-1:0]            rdata;
  logic [msd_pkg::DP_W-1:0]     rd_dp;
  logic [msd_pkg::PROC_W-1:0]   rd_proc;
  logic [msd_pkg::DIFF_W-1:0]   diff;
  logic [msd_pkg::SLACK_W-1:0]  slack;
  logic                         take;

  assign full       = (count_q == CW'(MAX_JOBS));
  assign last_round = ((round_q + CW'(1)) == count_q);

  // The store keeps due minus processing time, so a scan needs one subtract.
  assign wr_dp = {1'b0, in_data_i.due_date} - msd_pkg::DP_W'(in_data_i.proc_time);

  msd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_JOBS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load && !full),
    .waddr_i (count_q[IW-1:0]),
    .wdata_i ({wr_dp, in_data_i.proc_time}),
    .raddr_i (scan_q[IW-1:0]),
    .rdata_o (rdata)
  );

  assign rd_dp   = rdata[WORD_W-1 -: msd_pkg::DP_W];
  assign rd_proc = rdata[msd_pkg::PROC_W-1:0];
  assign diff    = {rd_dp[msd_pkg::DP_W-1], rd_dp} - msd_pkg::DIFF_W'(clock_q);
  assign slack   = diff[msd_pkg::DIFF_W-1] ? '0 : diff[msd_pkg::SLACK_W-1:0];

  // A strict compare keeps the lowest index on ties, since indexes arrive in order.
  assign take = s2_valid_q && (!found_q || (s2_slack_q < best_slack_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      overflow_q  <= 1'b0;
      clock_q     <= '0;
      round_q     <= '0;
      scan_q      <= '0;
      done_q      <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.set_clear) begin
        count_q    <= '0;
        overflow_q <= 1'b0;
      end else if (cmd_i.load) begin
        if (full) begin
          overflow_q <= 1'b1;
        end else begin
          count_q <= count_q + CW'(1);
        end
      end

      if (cmd_i.scan_init) begin
        scan_q <= '0;
      end else if (cmd_i.scan_issue) begin
        scan_q <= scan_q + CW'(1);
      end

      s1_valid_q <= cmd_i.scan_issue;
      s2_valid_q <= s1_valid_q && !done_q[s1_idx_q];

      if (cmd_i.scan_init) begin
        found_q <= 1'b0;
      end else if (take) begin
        found_q <= 1'b1;
      end

      if (cmd_i.commit) begin
        // The final commit of a set starts the next set from a clean state.
        if (cmd_i.set_clear) begin
          done_q  <= '0;
          clock_q <= '0;
          round_q <= '0;
        end else begin
          done_q[best_idx_q] <= 1'b1;
          clock_q            <= clock_q + msd_pkg::CLK_W'(best_proc_q);
          round_q            <= round_q + CW'(1);
        end
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q   <= scan_q[IW-1:0];
    s2_idx_q   <= s1_idx_q;
    s2_slack_q <= slack;
    s2_proc_q  <= rd_proc;
    if (take) begin
      best_slack_q <= s2_slack_q;
      best_idx_q   <= s2_idx_q;
      best_proc_q  <= s2_proc_q;
    end
    if (cmd_i.commit) begin
      out_q.job_index   <= 6'(best_idx_q);
      out_q.position    <= 7'(round_q) + 7'd1;
      out_q.start_time  <= clock_q;
      out_q.overflow    <= overflow_q;
      out_q.last_of_run <= last_round;
    end
  end

  assign sts_o.scan_end   = (scan_q == count_q);
  assign sts_o.pipe_busy  = s1_valid_q || s2_valid_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.last_round = last_round;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_JOBS))
    else $error("job count above capacity");

  a_commit_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> found_q)
    else $error("dispatch without a selected job");

  a_done_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && !cmd_i.set_clear |=> done_q[$past(best_idx_q)])
    else $error("dispatched job not marked done");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_issue |-> (scan_q < count_q))
    else $error("scan read beyond stored jobs");
`endif

endmodule

// File: rtl/core/min_slack_dispatch.sv
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i/in_ready_o   | in_data_i  (msd_pkg::in_t)
// out     | output    | out_valid_o/out_ready_i | out_data_o (msd_pkg::out_t)
//
// Load requests are taken back to back. After the request marked last, each of the n
// stored jobs costs one round: one store read per job on the single read port, two
// compare stages, a check that sees the stages empty, and a commit. Reset clears counts,
// clock, done marks and overflow; the job store is not cleared. Loads are refused during
// dispatch. A result waiting in the output register stalls only the next commit, and
// the final one does not hold off the next set's loads.
module min_slack_dispatch #(
  parameter int unsigned MAX_JOBS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  msd_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output msd_pkg::out_t out_data_o
);

  msd_pkg::ctrl_cmd_t cmd;
  msd_pkg::dp_sts_t   sts;

  msd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.last_job),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  msd_dpath #(
    .MAX_JOBS (MAX_JOBS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// File: verif/min_slack_checker.sv
module min_slack_checker
  import msd_pkg::*;
#(
  parameter int unsigned MAX_JOBS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_t        out_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  logic [DUE_W-1:0]  due_mem  [MAX_JOBS];
  logic [PROC_W-1:0] proc_mem [MAX_JOBS];
  int unsigned       stored_jobs;
  logic              dropped_seen;
  int unsigned       mismatches;
  out_t              schedule_q [$];

  function automatic logic [SLACK_W-1:0] slack_of(logic [DUE_W-1:0] due,
                                                  logic [PROC_W-1:0] proc,
                                                  logic [CLK_W-1:0] now);
    longint margin;
    margin = longint'(due) - longint'(proc) - longint'(now);
    return (margin > 0) ? SLACK_W'(margin) : '0;
  endfunction

  // Runs the whole minimum-slack schedule of the stored set and queues one
  // dispatch per job, then starts a new set.
  task automatic dispatch_min_slack();
    logic [CLK_W-1:0]   sched_clock;
    logic [SLACK_W-1:0] best_slack;
    logic [SLACK_W-1:0] cand_slack;
    logic [MAX_JOBS-1:0] taken;
    int unsigned        pick;
    int unsigned        r;
    int unsigned        j;
    bit                 found;
    out_t               res;
    sched_clock = '0;
    taken = '0;
    for (r = 0; r < stored_jobs; r++) begin
      found = 1'b0;
      pick = 0;
      best_slack = '0;
      for (j = 0; j < stored_jobs; j++) begin
        if (!taken[j]) begin
          cand_slack = slack_of(due_mem[j], proc_mem[j], sched_clock);
          // Strict compare keeps the lowest index on a tie.
          if (!found || cand_slack < best_slack) begin
            pick = j;
            best_slack = cand_slack;
            found = 1'b1;
          end
        end
      end
      res.job_index   = 6'(pick);
      res.position    = 7'(r + 1);
      res.start_time  = sched_clock;
      res.overflow    = dropped_seen;
      res.last_of_run = (r + 1 == stored_jobs);
      schedule_q.push_back(res);
      taken[pick] = 1'b1;
      sched_clock = sched_clock + CLK_W'(proc_mem[pick]);
    end
    stored_jobs = 0;
    dropped_seen = 1'b0;
  endtask

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      stored_jobs = 0;
      dropped_seen = 1'b0;
      mismatches = 0;
      schedule_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (schedule_q.size() == 0) begin
          $error("result with nothing expected: job_index %0d position %0d",
                 out_data_i.job_index, out_data_i.position);
          mismatches++;
        end else begin
          want = schedule_q.pop_front();
          check_field("job_index", want.job_index, out_data_i.job_index);
          check_field("position", want.position, out_data_i.position);
          check_field("start_time", want.start_time, out_data_i.start_time);
          check_field("overflow", want.overflow, out_data_i.overflow);
          check_field("last_of_run", want.last_of_run, out_data_i.last_of_run);
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (stored_jobs < MAX_JOBS) begin
          due_mem[stored_jobs]  = in_data_i.due_date;
          proc_mem[stored_jobs] = in_data_i.proc_time;
          stored_jobs++;
        end else begin
          dropped_seen = 1'b1;
        end
        if (in_data_i.last_job) begin
          dispatch_min_slack();
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= schedule_q.size();
  end

endmodule

// File: verif/min_slack_dispatch_test.sv
module min_slack_dispatch_test;
  import msd_pkg::*;

  localparam int unsigned MAX_JOBS     = 32;
  localparam int unsigned ITEM_TARGET  = 330;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 4 * (MAX_JOBS + 3);

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  out_t out_data;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned jobs_sent;
  bit          tx_quiet;

  always #1 clk = ~clk;

  min_slack_dispatch #(
    .MAX_JOBS(MAX_JOBS)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  min_slack_checker #(
    .MAX_JOBS(MAX_JOBS)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Valid stays high across back-to-back requests when the gap is zero.
  task automatic send_job(input logic [DUE_W-1:0] due, input logic [PROC_W-1:0] proc,
                          input logic last);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{due_date: due, proc_time: proc, last_job: last};
    do @(posedge clk); while (!in_ready);
    jobs_sent++;
  endtask

  task automatic send_random_set(input int unsigned count);
    int unsigned       mode;
    int unsigned       k;
    logic [DUE_W-1:0]  due;
    logic [PROC_W-1:0] proc;
    mode = $urandom_range(0, 2);
    tx_quiet = ($urandom_range(0, 3) == 0);
    for (k = 0; k < count; k++) begin
      if (mode == 0) begin
        due  = DUE_W'($urandom());
        proc = PROC_W'($urandom());
      end else if (mode == 1) begin
        // Small values give many ties and slacks that hit zero as the clock runs.
        due  = DUE_W'($urandom_range(0, 300));
        proc = PROC_W'($urandom_range(0, 60));
      end else begin
        proc = PROC_W'($urandom_range(0, 4000));
        due  = DUE_W'(proc) + DUE_W'($urandom_range(0, 20000));
      end
      send_job(due, proc, k + 1 == count);
    end
  endtask

  initial begin : stimulus
    int unsigned draw;
    int unsigned set_size;
    jobs_sent = 0;
    tx_quiet = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_job(24'hFFFFFF, 16'hFFFF, 1'b1);
    send_job(24'h000000, 16'h0000, 1'b1);
    // Equal slacks: dispatch must follow load order.
    send_job(24'd500, 16'd100, 1'b0);
    send_job(24'd500, 16'd100, 1'b0);
    send_job(24'd500, 16'd100, 1'b1);
    // Due dates below the processing time clamp the slack at zero.
    send_job(24'd100, 16'd10, 1'b0);
    send_job(24'd5, 16'd50, 1'b0);
    send_job(24'd0, 16'hFFFF, 1'b0);
    send_job(24'hFFFFFF, 16'h0000, 1'b1);
    send_job(24'd400, 16'd100, 1'b0);
    send_job(24'd250, 16'd50, 1'b0);
    send_job(24'hAAAAAA, 16'h5555, 1'b0);
    send_job(24'h555555, 16'hAAAA, 1'b1);

    while (jobs_sent < ITEM_TARGET) begin
      draw = $urandom_range(0, 9);
      if (draw < 6) begin
        set_size = $urandom_range(1, 6);
      end else if (draw < 8) begin
        set_size = $urandom_range(7, 16);
      end else if (draw < 9) begin
        set_size = ($urandom_range(0, 2) == 0) ? MAX_JOBS : $urandom_range(17, MAX_JOBS);
      end else begin
        // Overfull set: the extra requests, the last one among them, are dropped.
        set_size = $urandom_range(MAX_JOBS + 1, MAX_JOBS + 4);
      end
      send_random_set(set_size);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned stall;
    bit          rx_quiet;
    rx_quiet = 1'b0;
    forever begin
      if ($urandom_range(0, 15) == 0) rx_quiet = !rx_quiet;
      stall = rx_quiet ? 0 : $urandom_range(0, 12);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
